/* hw/rtl/magic_length_type_deframer_defines.svh */
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef MAGIC_LENGTH_TYPE_DEFRAMER_DEFINES_SVH
`define MAGIC_LENGTH_TYPE_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define MLTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MLTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mltd_pkg.sv */
// ----------------------------------------------------------------------------
// Deframer package
// Result kinds, header layout constants and the result transaction type.
// ----------------------------------------------------------------------------
package mltd_pkg;

    localparam int HEADER_BYTES_DEFAULT = 7;
    localparam int POS_LENGTH           = 4;
    localparam int POS_TYPE             = 6;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       out_kind;
        logic [7:0]  msg_type;
        logic [7:0]  out_byte;
        logic        last_of_frame;
        logic [31:0] seen_magic;
    } t_result;

endpackage

/* hw/rtl/mltd_ifs.sv */
// ----------------------------------------------------------------------------
// Deframer stream interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mltd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;

    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface mltd_out_if;
    logic            valid;
    logic            ready;
    mltd_pkg::t_kind out_kind;
    logic [7:0]      msg_type;
    logic [7:0]      out_byte;
    logic            last_of_frame;
    logic [31:0]     seen_magic;

    modport source (output valid, output out_kind, output msg_type, output out_byte,
                    output last_of_frame, output seen_magic, input ready);
    modport sink   (input valid, input out_kind, input msg_type, input out_byte,
                    input last_of_frame, input seen_magic, output ready);
endinterface

/* hw/rtl/magic_length_type_deframer.sv */
// ----------------------------------------------------------------------------
// Magic/length/type deframer
// Accepts one stream byte per cycle; each result is registered in the output
// register, or in the skid stage while the output is stalled. Throughput is
// one byte per cycle; input ready drops only while that skid stage is full.
// Synchronous active-low reset returns to header mode, clears the magic to
// zero and empties both result stages; no clearing pass follows.
// ----------------------------------------------------------------------------
module magic_length_type_deframer #(
    parameter int HEADER_BYTES = mltd_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_magic_word_we,
    input  logic [31:0] i_magic_word,
    mltd_in_if.sink     i_in,
    mltd_out_if.source  o_out
);

    mltd_pkg::t_result w_res;
    logic              w_ready;
    logic              w_accept;

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    mltd_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_in_byte       (i_in.in_byte),
        .i_chunk_end     (i_in.chunk_end),
        .i_magic_word_we (i_magic_word_we),
        .i_magic_word    (i_magic_word),
        .o_res           (w_res)
    );

    mltd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (w_res),
        .o_in_ready (w_ready),
        .o_out      (o_out)
    );

endmodule

/* hw/rtl/mltd_parser.sv */
// ----------------------------------------------------------------------------
// Deframer header/payload parser
// Collects the header, checks the magic, tags payload bytes, skips on error.
// ----------------------------------------------------------------------------
`include "magic_length_type_deframer_defines.svh"

module mltd_parser #(
    parameter int HEADER_BYTES = mltd_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_in_byte,
    input  logic              i_chunk_end,
    input  logic              i_magic_word_we,
    input  logic [31:0]       i_magic_word,
    output mltd_pkg::t_result o_res
);

    localparam int POS_W = $clog2(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(mltd_pkg::POS_LENGTH);
    localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(mltd_pkg::POS_TYPE);

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_DISCARD = 2'd2
    } t_mode;

    t_mode            r_mode,       n_mode;
    logic [POS_W-1:0] r_pos,        n_pos;
    logic [31:0]      r_magic,      n_magic;
    logic [15:0]      r_length,     n_length;
    logic [7:0]       r_type,       n_type;
    logic [15:0]      r_remaining,  n_remaining;
    logic [31:0]      r_magic_word;

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_magic     = r_magic;
        n_length    = r_length;
        n_type      = r_type;
        n_remaining = r_remaining;
        o_res       = '0;
        o_res.out_kind = mltd_pkg::KIND_PAYLOAD;
        if (i_accept) begin
            unique case (r_mode)
                MODE_PAYLOAD: begin
                    n_remaining         = r_remaining - 16'd1;
                    o_res.valid         = 1'b1;
                    o_res.out_kind      = mltd_pkg::KIND_PAYLOAD;
                    o_res.msg_type      = r_type;
                    o_res.out_byte      = i_in_byte;
                    o_res.last_of_frame = (n_remaining == 16'd0);
                    if (n_remaining == 16'd0) begin
                        n_mode = MODE_HEADER;
                    end
                end
                MODE_DISCARD: begin
                    if (i_chunk_end) begin
                        n_mode = MODE_HEADER;
                    end
                end
                default: begin
                    if (r_pos < POS_LENGTH) begin
                        n_magic = {i_in_byte, r_magic[31:8]};
                    end else if (r_pos < POS_TYPE) begin
                        n_length = {i_in_byte, r_length[15:8]};
                    end else if (r_pos == POS_TYPE) begin
                        n_type = i_in_byte;
                    end
                    if (r_pos != POS_LAST) begin
                        n_pos = r_pos + POS_W'(1);
                    end else begin
                        n_pos = '0;
                        if (n_magic != r_magic_word) begin
                            o_res.valid         = 1'b1;
                            o_res.out_kind      = mltd_pkg::KIND_ERROR;
                            o_res.msg_type      = n_type;
                            o_res.last_of_frame = 1'b1;
                            o_res.seen_magic    = n_magic;
                            n_mode = i_chunk_end ? MODE_HEADER : MODE_DISCARD;
                        end else if (n_length == 16'd0) begin
                            o_res.valid         = 1'b1;
                            o_res.out_kind      = mltd_pkg::KIND_EMPTY;
                            o_res.msg_type      = n_type;
                            o_res.last_of_frame = 1'b1;
                            n_mode = MODE_HEADER;
                        end else begin
                            n_remaining = n_length;
                            n_mode      = MODE_PAYLOAD;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_HEADER;
            r_pos        <= '0;
            r_magic_word <= '0;
        end else begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            if (i_magic_word_we) begin
                r_magic_word <= i_magic_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_magic     <= n_magic;
        r_length    <= n_length;
        r_type      <= n_type;
        r_remaining <= n_remaining;
    end

    `MLTD_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= POS_LAST,
        "header position beyond header size")
    `MLTD_ASSERT_NOW(a_payload_count, i_clk, i_rst_n, r_mode == MODE_PAYLOAD,
        r_remaining != 16'd0, "payload mode with no bytes remaining")
    `MLTD_ASSERT_NOW(a_result_needs_accept, i_clk, i_rst_n, o_res.valid, i_accept,
        "result produced without an accepted byte")

endmodule

/* hw/rtl/mltd_out_reg.sv */
// ----------------------------------------------------------------------------
// Deframer result register
// Output register with a one-entry skid stage; backpressures only when full.
// ----------------------------------------------------------------------------
`include "magic_length_type_deframer_defines.svh"

module mltd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mltd_pkg::t_result i_res,
    output logic              o_in_ready,
    mltd_out_if.source        o_out
);

    mltd_pkg::t_result r_out,  n_out;
    mltd_pkg::t_result r_skid, n_skid;
    logic              w_take;

    assign w_take     = r_out.valid && o_out.ready;
    assign o_in_ready = !r_skid.valid;

    assign o_out.valid         = r_out.valid;
    assign o_out.out_kind      = r_out.out_kind;
    assign o_out.msg_type      = r_out.msg_type;
    assign o_out.out_byte      = r_out.out_byte;
    assign o_out.last_of_frame = r_out.last_of_frame;
    assign o_out.seen_magic    = r_out.seen_magic;

    always_comb begin
        n_out  = r_out;
        n_skid = r_skid;
        if (!r_out.valid || w_take) begin
            if (r_skid.valid) begin
                n_out        = r_skid;
                n_skid.valid = 1'b0;
            end else begin
                n_out = i_res;
            end
        end else if (i_res.valid) begin
            n_skid = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            r_out  <= n_out;
            r_skid <= n_skid;
        end
    end

    `MLTD_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid.valid, r_out.valid,
        "skid entry held while output register empty")
    `MLTD_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid.valid && w_take,
        r_out.valid && !r_skid.valid, "skid entry not moved to output")
    `MLTD_ASSERT_NEXT(a_stall_capture, i_clk, i_rst_n,
        r_out.valid && !w_take && i_res.valid, r_skid.valid,
        "result lost while output stalled")

endmodule

/* tb/tb_magic_length_type_deframer.sv */
// ----------------------------------------------------------------------------
// Deframer testbench
// Drives a byte stream with chunk-end flags into the deframer and checks every
// result against an in-bench parser model, or the row's result for typed table
// rows. A short table of hand-written frames comes first, then random traffic
// under three magic settings and three idle mixes. Pressure comes from a long
// output hold while a long frame is offered, and from draining between phases.
// ----------------------------------------------------------------------------
module tb_magic_length_type_deframer;

    localparam int HDR_BYTES = mltd_pkg::HEADER_BYTES_DEFAULT;

    typedef enum logic [1:0] {
        PARSE_HEADER  = 2'd0,
        PARSE_PAYLOAD = 2'd1,
        PARSE_DISCARD = 2'd2
    } t_parse_mode;

    typedef struct packed {
        mltd_pkg::t_kind kind;
        logic [7:0]      msg_type;
        logic [7:0]      data;
        logic            last;
        logic [31:0]     seen_magic;
    } t_frame_result;

    typedef struct packed {
        logic [7:0]    data;
        logic          chunk_end;
        logic          typed;
        t_frame_result result;
    } t_stim_row;

    localparam t_frame_result NO_RESULT = '0;

    localparam t_stim_row DIRECTED_ROWS [30] = '{
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b1,
          '{mltd_pkg::KIND_EMPTY, 8'h00, 8'h00, 1'b1, 32'h0000_0000}},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1,
          '{mltd_pkg::KIND_PAYLOAD, 8'hFF, 8'hFF, 1'b1, 32'h0000_0000}},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hAB, 1'b1, 1'b1,
          '{mltd_pkg::KIND_ERROR, 8'hAB, 8'h00, 1'b1, 32'hFFFF_FFFF}},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h03, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, 1'b1,
          '{mltd_pkg::KIND_ERROR, 8'h5A, 8'h00, 1'b1, 32'h8000_0001}},
        '{8'h00, 1'b1, 1'b0, NO_RESULT}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_magic_word_we;
    logic [31:0] i_magic_word;

    mltd_in_if  stream_in ();
    mltd_out_if result_out ();

    magic_length_type_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_magic_word_we (i_magic_word_we),
        .i_magic_word    (i_magic_word),
        .i_in            (stream_in),
        .o_out           (result_out)
    );

    t_parse_mode   parse_mode;
    logic [3:0]    header_pos;
    logic [31:0]   magic_acc;
    logic [15:0]   length_acc;
    logic [7:0]    frame_type;
    logic [15:0]   bytes_left;
    logic [31:0]   magic_cfg;

    t_frame_result expected_results [$];
    t_frame_result predicted;
    logic          produced;
    logic          row_typed;
    t_frame_result row_result;

    logic [31:0]   magic_setting;
    int            src_idle_pct;
    int            sink_idle_pct;
    logic          hold_rx;
    int            mismatches;
    int            items_in;
    int            results_out;
    int            n_payload;
    int            n_empty;
    int            n_error;

    always #5 i_clk = ~i_clk;

    function automatic logic deframe_byte(input logic [7:0] data, input logic chunk_end,
                                          output t_frame_result res);
        res = NO_RESULT;
        if (parse_mode == PARSE_PAYLOAD) begin
            bytes_left = bytes_left - 16'd1;
            res = '{mltd_pkg::KIND_PAYLOAD, frame_type, data, bytes_left == 16'd0, 32'h0};
            if (bytes_left == 16'd0) begin
                parse_mode = PARSE_HEADER;
            end
            return 1'b1;
        end
        if (parse_mode == PARSE_DISCARD) begin
            if (chunk_end) begin
                parse_mode = PARSE_HEADER;
            end
            return 1'b0;
        end
        if (header_pos == 4'd0) begin
            magic_acc  = '0;
            length_acc = '0;
            frame_type = '0;
        end
        if (header_pos < mltd_pkg::POS_LENGTH) begin
            magic_acc = magic_acc | (32'(data) << (8 * header_pos));
        end else if (header_pos < mltd_pkg::POS_TYPE) begin
            length_acc = length_acc
                | 16'(32'(data) << (8 * (header_pos - mltd_pkg::POS_LENGTH)));
        end else if (header_pos == mltd_pkg::POS_TYPE) begin
            frame_type = data;
        end
        if (header_pos + 1 < HDR_BYTES) begin
            header_pos = header_pos + 4'd1;
            return 1'b0;
        end
        header_pos = 4'd0;
        if (magic_acc != magic_cfg) begin
            res = '{mltd_pkg::KIND_ERROR, frame_type, 8'h00, 1'b1, magic_acc};
            parse_mode = chunk_end ? PARSE_HEADER : PARSE_DISCARD;
            return 1'b1;
        end
        if (length_acc == 16'd0) begin
            res = '{mltd_pkg::KIND_EMPTY, frame_type, 8'h00, 1'b1, 32'h0};
            return 1'b1;
        end
        bytes_left = length_acc;
        parse_mode = PARSE_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_mode = PARSE_HEADER;
            header_pos = '0;
            magic_acc  = '0;
            length_acc = '0;
            frame_type = '0;
            bytes_left = '0;
            magic_cfg  = '0;
        end else begin
            if (result_out.valid && result_out.ready) begin
                results_out++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d byte 0x%0h",
                             $time, result_out.out_kind, result_out.out_byte);
                    mismatches++;
                end else begin
                    predicted = expected_results.pop_front();
                    check_field("out_kind", 32'(predicted.kind), 32'(result_out.out_kind));
                    check_field("msg_type", 32'(predicted.msg_type), 32'(result_out.msg_type));
                    check_field("out_byte", 32'(predicted.data), 32'(result_out.out_byte));
                    check_field("last_of_frame", 32'(predicted.last),
                                32'(result_out.last_of_frame));
                    check_field("seen_magic", predicted.seen_magic, result_out.seen_magic);
                end
            end
            if (i_magic_word_we) begin
                magic_cfg = i_magic_word;
            end
            if (stream_in.valid && stream_in.ready) begin
                items_in++;
                produced = deframe_byte(stream_in.in_byte, stream_in.chunk_end, predicted);
                if (row_typed) begin
                    predicted = row_result;
                    produced  = 1'b1;
                end
                if (produced) begin
                    expected_results.push_back(predicted);
                    case (predicted.kind)
                        mltd_pkg::KIND_PAYLOAD: n_payload++;
                        mltd_pkg::KIND_EMPTY:   n_empty++;
                        default:                n_error++;
                    endcase
                end
            end
        end
    end

    always @(negedge i_clk) begin
        result_out.ready <= !hold_rx && ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic put_byte(input logic [7:0] data, input logic chunk_end, input logic typed,
                            input t_frame_result result);
        stream_in.valid     <= 1'b1;
        stream_in.in_byte   <= data;
        stream_in.chunk_end <= chunk_end;
        row_typed           <= typed;
        row_result          <= result;
        do @(posedge i_clk); while (!stream_in.ready);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            stream_in.valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [31:0] magic, input logic [15:0] length,
                              input logic [7:0] ftype, input int n_body, input int ce_pct);
        logic [7:0] data;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (i < mltd_pkg::POS_LENGTH) begin
                data = magic[8 * i +: 8];
            end else if (i < mltd_pkg::POS_TYPE) begin
                data = length[8 * (i - mltd_pkg::POS_LENGTH) +: 8];
            end else if (i == mltd_pkg::POS_TYPE) begin
                data = ftype;
            end else begin
                data = 8'($urandom_range(255));
            end
            put_byte(data, $urandom_range(99) < ce_pct, 1'b0, NO_RESULT);
        end
        for (int i = 0; i < n_body; i++) begin
            put_byte(8'($urandom_range(255)), $urandom_range(99) < ce_pct, 1'b0, NO_RESULT);
        end
    endtask

    task automatic realign();
        while (parse_mode != PARSE_HEADER || header_pos != 4'd0) begin
            put_byte(8'h00, 1'b1, 1'b0, NO_RESULT);
        end
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        while (expected_results.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            mismatches++;
            expected_results.delete();
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        i_magic_word_we <= 1'b1;
        i_magic_word    <= value;
        magic_setting   = value;
        @(negedge i_clk);
        i_magic_word_we <= 1'b0;
    endtask

    task automatic run_traffic(input int n_items);
        int          stop_at;
        int          pick;
        logic [15:0] length;
        logic [31:0] bad_magic;
        stop_at = items_in + n_items;
        while (items_in < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                if ($urandom_range(9) == 0) begin
                    length = 16'($urandom_range(300, 13));
                end else begin
                    length = 16'($urandom_range(12));
                end
                send_frame(magic_setting, length, 8'($urandom_range(255)), int'(length), 10);
            end else if (pick < 90) begin
                if ($urandom_range(1) == 1) begin
                    bad_magic = magic_setting ^ (32'h1 << $urandom_range(31));
                end else begin
                    bad_magic = $urandom();
                end
                if (bad_magic == magic_setting) begin
                    bad_magic = ~bad_magic;
                end
                send_frame(bad_magic, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                           int'($urandom_range(6)), 30);
                realign();
            end else begin
                repeat ($urandom_range(10, 1)) begin
                    put_byte(8'($urandom_range(255)), $urandom_range(99) < 30, 1'b0, NO_RESULT);
                end
                realign();
            end
        end
        stream_in.valid <= 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        i_magic_word_we     = 1'b0;
        i_magic_word        = '0;
        stream_in.valid     = 1'b0;
        stream_in.in_byte   = '0;
        stream_in.chunk_end = 1'b0;
        result_out.ready    = 1'b0;
        row_typed           = 1'b0;
        row_result          = NO_RESULT;
        magic_setting       = '0;
        hold_rx             = 1'b0;
        src_idle_pct        = 24;
        sink_idle_pct       = 63;
        mismatches          = 0;
        items_in            = 0;
        results_out         = 0;
        n_payload           = 0;
        n_empty             = 0;
        n_error             = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            put_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].chunk_end,
                     DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
        end
        stream_in.valid <= 1'b0;
        wait_for_results();

        write_magic($urandom());
        run_traffic(450);
        wait_for_results();

        src_idle_pct  = 63;
        sink_idle_pct = 24;
        write_magic(32'hFFFF_FFFF);
        run_traffic(450);
        wait_for_results();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_magic(32'h0000_0000);
        run_traffic(400);
        wait_for_results();

        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
                @(negedge i_clk);
            end
            begin
                send_frame(magic_setting, 16'd120, 8'h96, 120, 10);
                stream_in.valid <= 1'b0;
            end
        join
        wait_for_results();

        $display("Run moved %0d stream bytes and %0d results:", items_in, results_out);
        $display("  %0d payload, %0d empty, %0d bad magic.", n_payload, n_empty, n_error);
        $display("Magic at reset value, random, all ones and zero; long output hold.");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mltd_pkg.sv
hw/rtl/mltd_ifs.sv
hw/rtl/mltd_parser.sv
hw/rtl/mltd_out_reg.sv
hw/rtl/magic_length_type_deframer.sv
tb/tb_magic_length_type_deframer.sv
